[rtl/core/assert_macros.svh]
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the stream clock and reset.
`define ASSERT_AXIS(label, prop, msg) \
    `ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

[rtl/core/jcpsr_pkg.sv]
// Shared types, constants and helpers of the joint command parser and servo ramp.
// No dependencies.
package jcpsr_pkg;

    localparam int JOINT_COUNT_DEF = 4;
    localparam int MAX_DIGITS_DEF  = 3;

    localparam int NUM_CAL   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CAL_W     = 52;
    localparam int ANG_W     = 8;
    localparam int PULSE_W   = 12;
    localparam int CH_W      = 4;
    localparam int JNT_W     = 2;
    localparam int DIGIT_W   = 10;
    localparam int DCNT_W    = 2;
    localparam int PROD_W    = ANG_W + PULSE_W;
    localparam int DIV_BITS  = 2;
    localparam int DIV_CYC   = PROD_W / DIV_BITS;
    localparam int DIVC_W    = $clog2(DIV_CYC);
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam logic [7:0] CH_BASE     = 8'h62;
    localparam logic [7:0] CH_SHOULDER = 8'h73;
    localparam logic [7:0] CH_ELBOW    = 8'h65;
    localparam logic [7:0] CH_GRIP     = 8'h67;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    typedef logic [CAL_W-1:0] cal_t;

    localparam cal_t CAL_RESET [NUM_CAL] = '{
        52'd1600562514514030, 52'd1596164468002936,
        52'd1591766421491822, 52'd3685083086945
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic take_item;
        logic load_mul;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick_emits;
        logic div_last;
        logic out_free;
    } dp_stat_t;

    function automatic logic [PULSE_W-1:0] cal_pmin(input cal_t c);
        return c[11:0];
    endfunction

    function automatic logic [PULSE_W-1:0] cal_pmax(input cal_t c);
        return c[23:12];
    endfunction

    function automatic logic [ANG_W-1:0] cal_amin(input cal_t c);
        return c[31:24];
    endfunction

    function automatic logic [ANG_W-1:0] cal_amax(input cal_t c);
        return c[39:32];
    endfunction

    function automatic logic [CH_W-1:0] cal_chan(input cal_t c);
        return c[43:40];
    endfunction

    function automatic logic [ANG_W-1:0] cal_start(input cal_t c);
        return c[51:44];
    endfunction

    // Clamp to [amin, amax]; an inverted range yields amin below amin, else amax.
    function automatic logic [ANG_W-1:0] clamp_ang(input logic [DIGIT_W-1:0] a,
                                                   input cal_t c);
        logic [DIGIT_W-1:0] lo;
        logic [DIGIT_W-1:0] hi;
        lo = {{(DIGIT_W-ANG_W){1'b0}}, cal_amin(c)};
        hi = {{(DIGIT_W-ANG_W){1'b0}}, cal_amax(c)};
        if (a < lo) begin
            return cal_amin(c);
        end else if (a > hi) begin
            return cal_amax(c);
        end
        return a[ANG_W-1:0];
    endfunction

endpackage

[rtl/core/jcpsr_ctrl.sv]
// Sequencer of the joint command parser: accept, multiply, divide, output.
// Depends on jcpsr_pkg.
module jcpsr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  jcpsr_pkg::dp_stat_t   stat,
    output jcpsr_pkg::ctrl_cmd_t  cmd
);
    import jcpsr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && stat.tick_emits) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.take_item = s_tvalid;
            end
            ST_MUL: begin
                cmd.load_mul = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_OUT: begin
                cmd.load_out = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/jcpsr_dp.sv]
// Datapath: command parser state, ramp state, pulse map with radix-4 divider,
// output register. Depends on jcpsr_pkg.
module jcpsr_dp #(
    parameter int JOINT_COUNT = jcpsr_pkg::JOINT_COUNT_DEF,
    parameter int MAX_DIGITS  = jcpsr_pkg::MAX_DIGITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  jcpsr_pkg::ctrl_cmd_t              cmd,
    output jcpsr_pkg::dp_stat_t               stat,
    input  logic                              s_tuser,
    input  logic [jcpsr_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                              cfg_we,
    input  logic [jcpsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jcpsr_pkg::CAL_W-1:0]       cfg_wdata,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [jcpsr_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);
    import jcpsr_pkg::*;

    cal_t               cal_reg [NUM_CAL];
    logic [JNT_W-1:0]   sel_reg, sel_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [DIGIT_W-1:0] dval_reg, dval_next;
    logic [ANG_W-1:0]   jang_reg [NUM_CAL];
    logic [ANG_W-1:0]   jang_next [NUM_CAL];
    logic               active_reg, active_next;
    logic               final_reg, final_next;
    logic [ANG_W-1:0]   step_reg, step_next;
    logic [ANG_W-1:0]   goal_reg, goal_next;
    logic [ANG_W-1:0]   ang_reg, ang_next;
    logic               last_reg, last_next;

    logic [PROD_W-1:0]  nq_reg, nq_next;
    logic [ANG_W-1:0]   rem_reg, rem_next;
    logic [ANG_W-1:0]   den_reg;
    logic               neg_reg;
    logic               byp_reg;
    logic [PULSE_W-1:0] bval_reg;
    logic [PULSE_W-1:0] pmin_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [DIVC_W-1:0]  dcyc_reg;

    logic               mvalid_reg;
    logic [CH_W-1:0]    mch_reg;
    logic [PULSE_W-1:0] mpulse_reg;
    logic [JNT_W-1:0]   mjnt_reg;
    logic               mlast_reg;

    cal_t               c_sel;
    logic               sel_hit;
    logic [JNT_W-1:0]   sel_idx;
    logic               is_digit;
    logic [DIGIT_W+3:0] dmul;

    // map stage
    logic [ANG_W-1:0]   amin, amax, a_cl, da;
    logic [PULSE_W-1:0] pmin, pmax, mag;
    logic [PROD_W-1:0]  prod;
    logic [PULSE_W-1:0] pulse;

    assign c_sel = cal_reg[sel_reg];

    always_comb begin
        sel_hit = 1'b1;
        sel_idx = '0;
        case (s_tdata)
            CH_BASE:     sel_idx = JNT_W'(0);
            CH_SHOULDER: sel_idx = JNT_W'(1);
            CH_ELBOW:    sel_idx = JNT_W'(2);
            CH_GRIP:     sel_idx = JNT_W'(3);
            default:     sel_hit = 1'b0;
        endcase
    end

    assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign dmul = ({4'b0, dval_reg} << 3) + ({4'b0, dval_reg} << 1)
                + {{DIGIT_W{1'b0}}, s_tdata[3:0] - CH_ZERO[3:0]};

    always_comb begin
        sel_next    = sel_reg;
        dcnt_next   = dcnt_reg;
        dval_next   = dval_reg;
        jang_next   = jang_reg;
        active_next = active_reg;
        final_next  = final_reg;
        step_next   = step_reg;
        goal_next   = goal_reg;
        ang_next    = ang_reg;
        last_next   = last_reg;
        if (cmd.take_item) begin
            if (s_tuser) begin
                if (active_reg) begin
                    if (final_reg) begin
                        ang_next           = goal_reg;
                        last_next          = 1'b1;
                        jang_next[sel_reg] = goal_reg;
                        active_next        = 1'b0;
                        final_next         = 1'b0;
                    end else begin
                        ang_next  = step_reg;
                        last_next = 1'b0;
                        if (step_reg == goal_reg) begin
                            final_next = 1'b1;
                        end else if (step_reg < goal_reg) begin
                            step_next = step_reg + ANG_W'(1);
                        end else begin
                            step_next = step_reg - ANG_W'(1);
                        end
                    end
                end
            end else if (!active_reg) begin
                if (sel_hit) begin
                    if (int'(sel_idx) < JOINT_COUNT) begin
                        sel_next  = sel_idx;
                        dcnt_next = '0;
                        dval_next = '0;
                    end
                end else if (s_tdata == CH_COMMA) begin
                    goal_next   = clamp_ang(dval_reg, c_sel);
                    step_next   = jang_reg[sel_reg];
                    active_next = 1'b1;
                    final_next  = 1'b0;
                    dcnt_next   = '0;
                    dval_next   = '0;
                end else if (is_digit && (int'(dcnt_reg) < MAX_DIGITS)) begin
                    dval_next = dmul[DIGIT_W-1:0];
                    dcnt_next = dcnt_reg + DCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CAL; i++) begin
                cal_reg[i]  <= CAL_RESET[i];
                jang_reg[i] <= cal_start(CAL_RESET[i]);
            end
            sel_reg    <= '0;
            dcnt_reg   <= '0;
            dval_reg   <= '0;
            active_reg <= 1'b0;
            final_reg  <= 1'b0;
            step_reg   <= '0;
            goal_reg   <= '0;
        end else begin
            if (cfg_we) begin
                cal_reg[cfg_index] <= cfg_wdata;
            end
            jang_reg   <= jang_next;
            sel_reg    <= sel_next;
            dcnt_reg   <= dcnt_next;
            dval_reg   <= dval_next;
            active_reg <= active_next;
            final_reg  <= final_next;
            step_reg   <= step_next;
            goal_reg   <= goal_next;
        end
    end

    always_ff @(posedge aclk) begin
        ang_reg  <= ang_next;
        last_reg <= last_next;
    end

    // Map stage: clamp, span and product of the emitted angle.
    assign amin = cal_amin(c_sel);
    assign amax = cal_amax(c_sel);
    assign pmin = cal_pmin(c_sel);
    assign pmax = cal_pmax(c_sel);
    assign a_cl = clamp_ang({{(DIGIT_W-ANG_W){1'b0}}, ang_reg}, c_sel);
    assign da   = a_cl - amin;
    assign mag  = (pmax < pmin) ? (pmin - pmax) : (pmax - pmin);
    assign prod = {{PULSE_W{1'b0}}, da} * {{ANG_W{1'b0}}, mag};

    // Restoring divide, DIV_BITS quotient bits per cycle.
    always_comb begin
        logic [ANG_W:0]    t;
        logic [ANG_W-1:0]  r;
        logic [PROD_W-1:0] n;
        r = rem_reg;
        n = nq_reg;
        for (int k = 0; k < DIV_BITS; k++) begin
            t = {r, n[PROD_W-1]};
            n = {n[PROD_W-2:0], 1'b0};
            if (t >= {1'b0, den_reg}) begin
                t    = t - {1'b0, den_reg};
                n[0] = 1'b1;
            end
            r = t[ANG_W-1:0];
        end
        rem_next = r;
        nq_next  = n;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_mul) begin
            nq_reg   <= prod;
            rem_reg  <= '0;
            den_reg  <= amax - amin;
            neg_reg  <= pmax < pmin;
            byp_reg  <= amin >= amax;
            bval_reg <= ((amin == amax) || (ang_reg < amin)) ? pmin : pmax;
            pmin_reg <= pmin;
            ch_reg   <= cal_chan(c_sel);
        end else if (cmd.div_step) begin
            nq_reg  <= nq_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcyc_reg <= '0;
        end else if (cmd.load_mul) begin
            dcyc_reg <= '0;
        end else if (cmd.div_step) begin
            dcyc_reg <= dcyc_reg + DIVC_W'(1);
        end
    end

    assign pulse = byp_reg ? bval_reg
                 : (neg_reg ? (pmin_reg - nq_reg[PULSE_W-1:0])
                            : (pmin_reg + nq_reg[PULSE_W-1:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            mch_reg    <= ch_reg;
            mpulse_reg <= pulse;
            mjnt_reg   <= sel_reg;
            mlast_reg  <= last_reg;
        end
    end

    assign stat.tick_emits = s_tuser && active_reg;
    assign stat.div_last   = (dcyc_reg == DIVC_W'(DIV_CYC - 1));
    assign stat.out_free   = !mvalid_reg || m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {{(OUT_DATA_W-CH_W-PULSE_W-JNT_W){1'b0}}, mjnt_reg, mpulse_reg, mch_reg};

endmodule

[rtl/core/joint_command_parser_servo_ramp.sv]
// Joint command parser with one-degree-per-tick servo ramp, top level.
// Depends on jcpsr_pkg, jcpsr_ctrl, jcpsr_dp.
//
// Input stream: s_tuser = 0 carries a serial byte in s_tdata, s_tuser = 1 is a
// motion tick. Joint letters select a joint, digits build the goal, a comma
// starts a move. During a move each tick produces one pulse write on the
// output stream; the extra goal write that ends the move has m_tlast set.
// Calibration is written through cfg_we/cfg_index/cfg_wdata, one 52-bit
// register per joint; the user must write it only while the block is idle,
// which the block itself does not enforce. A byte or a tick that writes nothing
// is taken while the sequencer stays in ST_IDLE. A tick that writes a pulse
// holds s_tready low through the product step, the radix-4 divider steps and
// the output load, so no further item is taken until it is loaded. The result
// shows on m_tvalid the cycle after the load.
// If the receiver stalls, the result stays in the output register and the
// next item is still accepted; a further result waits in the datapath until
// the output register frees.
// Reset loads the reset calibration and start angles and clears the parser,
// the move and the output register.
module joint_command_parser_servo_ramp #(
    parameter int JOINT_COUNT = jcpsr_pkg::JOINT_COUNT_DEF,
    parameter int MAX_DIGITS  = jcpsr_pkg::MAX_DIGITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [jcpsr_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    input  logic                              s_tuser,   // [0] command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] pwm_channel, [15:4] pulse_ticks, [17:16] joint_number, rest zero
    output logic [jcpsr_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                              m_tlast,   // move_done
    input  logic                              cfg_we,
    input  logic [jcpsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jcpsr_pkg::CAL_W-1:0]       cfg_wdata
);
    import jcpsr_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    jcpsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    jcpsr_dp #(
        .JOINT_COUNT (JOINT_COUNT),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[rtl/core/jcpsr_checker.sv]
// Port-level checks for the joint command parser, bound to the top level.
// Depends on jcpsr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jcpsr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [jcpsr_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                              m_tlast
);
    import jcpsr_pkg::*;

    `ASSERT_AXIS(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    `ASSERT_AXIS(a_rise_busy, $rose(m_tvalid) |-> !$past(s_tready), "result appeared without compute")
    `ASSERT_AXIS(a_byte_quiet, s_tvalid && s_tready && !s_tuser |=> !$rose(m_tvalid), "serial byte produced a result")

endmodule

bind joint_command_parser_servo_ramp jcpsr_checker u_jcpsr_checker (.*);

[verif/joint_command_parser_servo_ramp_test.sv]
// Self-checking testbench for joint_command_parser_servo_ramp: serial command bytes and motion
// ticks in, predicted servo pulse writes compared field by field out. Depends on jcpsr_pkg and
// the RTL of the block.
module joint_command_parser_servo_ramp_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jcpsr_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx;
    } serial_item_t;

    typedef struct packed {
        logic [3:0]  chan;
        logic [11:0] pulse;
        logic [1:0]  joint;
        logic        done;
    } pulse_write_t;

    typedef struct packed {
        cal_t [3:0]      cal;
        logic [1:0]      sel;
        logic [1:0]      ndig;
        logic [9:0]      value;
        logic [3:0][7:0] angle;
        logic            moving;
        logic            final_due;
        logic [7:0]      step;
        logic [7:0]      goal;
    } ramp_state_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    cal_t        cfg_wdata = '0;

    serial_item_t items_pending[$];
    pulse_write_t writes_due[$];
    ramp_state_t  live;
    ramp_state_t  plan;
    int           gap_left;
    int           stall_left;
    int           idle_pct = 0;
    int           stall_pct = 0;
    bit           calm = 1'b0;
    int           errors = 0;
    int           quiet = 0;
    int           sent_count = 0;

    joint_command_parser_servo_ramp u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic cal_t cal_word(logic [11:0] pmin, logic [11:0] pmax, logic [7:0] lo,
                                      logic [7:0] hi, logic [3:0] ch, logic [7:0] start);
        return {start, ch, hi, lo, pmax, pmin};
    endfunction

    function automatic ramp_state_t power_on_state();
        ramp_state_t st;
        st = '0;
        for (int i = 0; i < NUM_CAL; i++) begin
            st.cal[i] = CAL_RESET[i];
            st.angle[i] = CAL_RESET[i][51:44];
        end
        return st;
    endfunction

    function automatic logic [7:0] clamp_deg(cal_t c, logic [9:0] v);
        if (v < {2'b00, c[31:24]}) return c[31:24];
        if (v > {2'b00, c[39:32]}) return c[39:32];
        return v[7:0];
    endfunction

    function automatic pulse_write_t servo_pulse(cal_t c, logic [1:0] j, logic [7:0] deg,
                                                 logic last);
        pulse_write_t w;
        longint pmin, pmax, lo, hi, a, p;
        pmin = longint'(c[11:0]);
        pmax = longint'(c[23:12]);
        lo = longint'(c[31:24]);
        hi = longint'(c[39:32]);
        a = longint'(clamp_deg(c, {2'b00, deg}));
        p = pmin;
        if (hi != lo) p = (a - lo) * (pmax - pmin) / (hi - lo) + pmin;
        w.chan = c[43:40];
        w.pulse = p[11:0];
        w.joint = j;
        w.done = last;
        return w;
    endfunction

    // Advances the parser/ramp state by one item; returns 1 when a pulse write results.
    function automatic bit ramp_step(inout ramp_state_t st, input logic cmd,
                                     input logic [7:0] rx, output pulse_write_t w);
        logic [1:0] j;
        int pick;
        j = st.sel;
        w = '0;
        pick = -1;
        if (cmd) begin
            if (!st.moving) return 1'b0;
            if (st.final_due) begin
                w = servo_pulse(st.cal[j], j, st.goal, 1'b1);
                st.angle[j] = st.goal;
                st.moving = 1'b0;
                st.final_due = 1'b0;
            end else begin
                w = servo_pulse(st.cal[j], j, st.step, 1'b0);
                if (st.step == st.goal) st.final_due = 1'b1;
                else if (st.step < st.goal) st.step = st.step + 8'd1;
                else st.step = st.step - 8'd1;
            end
            return 1'b1;
        end
        if (st.moving) return 1'b0;
        case (rx)
            CH_BASE:     pick = 0;
            CH_SHOULDER: pick = 1;
            CH_ELBOW:    pick = 2;
            CH_GRIP:     pick = 3;
            default:     pick = -1;
        endcase
        if (pick >= 0) begin
            if (pick < JOINT_COUNT_DEF) begin
                st.sel = 2'(pick);
                st.ndig = '0;
                st.value = '0;
            end
            return 1'b0;
        end
        if (rx == CH_COMMA) begin
            st.goal = clamp_deg(st.cal[j], st.value);
            st.step = st.angle[j];
            st.moving = 1'b1;
            st.final_due = 1'b0;
            st.ndig = '0;
            st.value = '0;
        end else if (rx >= CH_ZERO && rx <= CH_NINE && st.ndig < MAX_DIGITS_DEF) begin
            st.value = 10'(int'(st.value) * 10 + int'(rx - CH_ZERO));
            st.ndig = st.ndig + 2'd1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] joint_letter(int unsigned j);
        case (j)
            0:       return CH_BASE;
            1:       return CH_SHOULDER;
            2:       return CH_ELBOW;
            default: return CH_GRIP;
        endcase
    endfunction

    function automatic cal_t random_cal();
        logic [7:0] lo, hi;
        lo = 8'($urandom_range(0, 255));
        hi = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: hi = lo;
            3: if (lo < hi) {lo, hi} = {hi, lo};
            default: begin
                lo = 8'($urandom_range(0, 200));
                hi = lo + 8'($urandom_range(1, 255 - int'(lo)));
            end
        endcase
        return cal_word(12'($urandom), 12'($urandom), lo, hi, 4'($urandom), 8'($urandom));
    endfunction

    task automatic send(input logic cmd, input logic [7:0] rx);
        pulse_write_t w;
        void'(ramp_step(plan, cmd, rx, w));
        items_pending.push_back('{cmd, rx});
        sent_count++;
    endtask

    task automatic finish_move(input bit chatter);
        while (plan.moving) begin
            if (chatter && $urandom_range(0, 9) == 0) send(1'b0, 8'($urandom_range(0, 255)));
            send(1'b1, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_move(input int unsigned j, input bit with_digits, input int target,
                            input int unsigned spill, input bit intrude);
        string s;
        finish_move(1'b0);
        send(1'b0, joint_letter(j));
        if (with_digits) begin
            s = $sformatf("%0d", target);
            if (s.len() < 3 && $urandom_range(0, 3) == 0) s = {"0", s};
            for (int i = 0; i < s.len(); i++) send(1'b0, s[i]);
            repeat (spill) send(1'b0, 8'(CH_ZERO + $urandom_range(0, 9)));
        end
        send(1'b0, CH_COMMA);
        if (intrude) send(1'b0, 8'($urandom_range(0, 255)));
        finish_move(1'b1);
    endtask

    task automatic load_cals(input cal_t [3:0] c);
        for (int i = 0; i < NUM_CAL; i++) begin
            @(posedge aclk);
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= c[i];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        plan = live;
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (items_pending.size() != 0 || s_tvalid || writes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : drive
        pulse_write_t w;
        serial_item_t nxt;
        if (!aresetn) begin
            live = power_on_state();
            gap_left <= 0;
            s_tvalid <= 1'b0;
        end else begin
            if (cfg_we) live.cal[cfg_index] = cfg_wdata;
            if (s_tvalid && s_tready) begin
                if (ramp_step(live, s_tuser, s_tdata, w)) writes_due.push_back(w);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (items_pending.size() != 0) begin
                    nxt = items_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= nxt.cmd;
                    s_tdata <= nxt.rx;
                    if (!calm && $urandom_range(0, 99) < idle_pct)
                        gap_left <= $urandom_range(1, 9);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : observe
        pulse_write_t want, got;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[3:0], m_tdata[15:4], m_tdata[17:16], m_tlast};
                if (writes_due.size() == 0) begin
                    $error("unexpected pulse write transfer: tdata %h tlast %b", m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = writes_due.pop_front();
                    if (got.chan !== want.chan) begin
                        $error("pwm_channel: expected %0d, got %0d", want.chan, got.chan);
                        errors++;
                    end
                    if (got.pulse !== want.pulse) begin
                        $error("pulse_ticks: expected %0d, got %0d", want.pulse, got.pulse);
                        errors++;
                    end
                    if (got.joint !== want.joint) begin
                        $error("joint_number: expected %0d, got %0d", want.joint, got.joint);
                        errors++;
                    end
                    if (got.done !== want.done) begin
                        $error("move_done: expected %0d, got %0d", want.done, got.done);
                        errors++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                stall_left <= $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : scenario
        cal_t [3:0] words;
        logic [7:0] lo;
        int unsigned j;
        int target;
        int unsigned r;
        int quota;
        plan = power_on_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset calibration: idle ticks, stray byte, in-place move, joint letter after the move
        idle_pct = 30;
        stall_pct = 30;
        send(1'b1, 8'hFF);
        send(1'b0, 8'h00);
        run_move(0, 1'b1, int'(plan.angle[0]), 0, 1'b0);
        send(1'b0, CH_SHOULDER);
        send(1'b1, 8'h00);
        drain();

        // empty range at all-ones, inverted range, full span, start outside range
        words[0] = cal_word(12'hFFF, 12'hFFF, plan.angle[0], plan.angle[0], 4'hF, 8'hFF);
        lo = (plan.angle[1] == 8'd0) ? 8'd1 : plan.angle[1];
        words[1] = cal_word(12'h000, 12'hFFF, lo, lo - 8'd1, 4'h5, 8'h00);
        words[2] = cal_word(12'h000, 12'hFFF, 8'h00, 8'hFF, 4'h0, 8'h00);
        lo = (plan.angle[3] <= 8'd252) ? plan.angle[3] + 8'd2 : plan.angle[3] - 8'd3;
        words[3] = cal_word(12'h123, 12'hEDC, lo, lo + 8'd1, 4'hA, 8'h5A);
        load_cals(words);
        run_move(0, 1'b1, 999, 1, 1'b0);
        run_move(1, 1'b0, 0, 0, 1'b1);
        run_move(2, 1'b1, (plan.angle[2] == 8'd255) ? 254 : int'(plan.angle[2]) + 1, 0, 1'b0);
        run_move(3, 1'b0, 0, 0, 1'b0);
        send(1'b1, 8'h5A);
        drain();

        quota = sent_count;
        for (int phase = 0; phase < 8; phase++) begin
            for (int i = 0; i < NUM_CAL; i++) words[i] = random_cal();
            load_cals(words);
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 25;
                default: idle_pct = 60;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                default: stall_pct = 60;
            endcase
            calm = (phase == 7);
            quota += 200;
            while (sent_count < quota) begin
                if ($urandom_range(0, 99) < 85) begin
                    j = $urandom_range(0, 3);
                    r = $urandom_range(0, 19);
                    if (r == 0) begin
                        target = int'($urandom_range(0, 999));
                    end else begin
                        target = int'(plan.angle[j]) + int'($urandom_range(0, 20)) - 10;
                        if (target < 0) target = 0;
                    end
                    run_move(j, r != 1, target,
                             ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0,
                             $urandom_range(0, 9) == 0);
                end else begin
                    case ($urandom_range(0, 2))
                        0: send(1'b0, 8'($urandom_range(0, 255)));
                        1: send(1'b1, 8'($urandom_range(0, 255)));
                        default: begin
                            send(1'b0, joint_letter($urandom_range(0, 3)));
                            repeat ($urandom_range(1, 4))
                                send(1'b0, 8'(CH_ZERO + $urandom_range(0, 9)));
                        end
                    endcase
                end
            end
            finish_move(1'b0);
            drain();
        end

        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
